// ----- design/dept_pkg.sv -----
// shared constants and fixed-point helpers for the passive torque core
package dept_pkg;

    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int REG_COUNT = 8;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef enum logic [2:0] {
        REG_GAIN_ONE  = 3'd0,
        REG_RATE_ONE  = 3'd1,
        REG_GAIN_TWO  = 3'd2,
        REG_RATE_TWO  = 3'd3,
        REG_MID       = 3'd4,
        REG_EQ_TORQUE = 3'd5,
        REG_VEL_GAIN  = 3'd6,
        REG_SLACK     = 3'd7
    } reg_index_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7fffffff)
            r = 32'sh7fffffff;
        else if (v < -66'sh80000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > 66'sh7fffffff) || (v < -66'sh80000000);
    endfunction

    // q16.16 product rounding: add one half, then floor shift
    function automatic logic signed [65:0] rnd16(input logic signed [63:0] p);
        logic signed [65:0] w;
        w = 66'(p) + 66'sd32768;
        return w >>> 16;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res = 64'd0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // entry i of the 2^(i/2^bits) table in unsigned q2.30
    function automatic logic [31:0] pow2_entry(input int i, input int bits);
        logic [63:0] roots [0:12];
        logic [63:0] acc;
        acc = 64'd1 << 30;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= 12; j++)
            roots[j] = (j <= bits) ? isqrt64(roots[j - 1] << 30) : 64'd0;
        if (i >= (1 << bits))
            acc = 64'd1 << 31;
        else
            for (int j = 11; j >= 0; j--)
                if (j < bits && ((i >> j) & 1) == 1)
                    acc = (acc * roots[bits - j] + (64'd1 << 29)) >> 30;
        return acc[31:0];
    endfunction

endpackage

// ----- design/double_exponential_passive_torque_core.sv -----
// top level: pipelined double-exponential passive joint torque
//
// usage: drive joint_angle and joint_velocity with start high for one cycle per item.
// busy is always low, so an item may enter on every clock edge.
// each item yields one result: done pulses for one cycle with torque and saturated.
// each item walks through fourteen register stages from the accepting edge to the done
// cycle; throughput is one item per cycle.
// the exp path uses a constant table of 2^EXP_TABLE_BITS+1 entries with linear
// interpolation, one lookup per exponential lane.
// registers are written through wr_en, wr_index and wr_data; the user must write them only
// while no item is in flight, which the block does not enforce; indexes follow gain_one,
// rate_one, gain_two, rate_two, mid_angle, equilibrium_torque, velocity_gain, slack_angle.
// reset clears all configuration registers to zero and empties the pipeline.
// the receiver cannot stall; results are presented once and not held.
// saturated reports any clip to the q16.16 range along the item's path.
module double_exponential_passive_torque_core
    import dept_pkg::*;
#(
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] joint_angle,
    input  logic signed [31:0] joint_velocity,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data,
    output logic               done,
    output logic signed [31:0] torque,
    output logic               saturated
);

    localparam int K = 16 - EXP_TABLE_BITS;
    localparam int TBL_LEN = (1 << EXP_TABLE_BITS) + 1;
    localparam int NSTG = 14;
    localparam int VEL_TAP = 10;
    localparam int LIN_TAP = 12;

    logic signed [31:0] cfg_reg [REG_COUNT];
    logic [31:0] pow_tbl [TBL_LEN];

    genvar gi;
    generate
        for (gi = 0; gi < TBL_LEN; gi++)
        begin : g_tbl
            assign pow_tbl[gi] = pow2_entry(gi, EXP_TABLE_BITS);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                cfg_reg[i] <= '0;
        end
        else if (wr_en)
            cfg_reg[wr_index] <= wr_data;
    end

    logic [NSTG:1] valid_reg;
    logic [NSTG:1] flag_reg;
    logic signed [31:0] vel_reg [VEL_TAP:2];
    logic signed [31:0] lin_reg [LIN_TAP:1];

    // stage payload
    logic signed [31:0] d_reg;
    logic signed [63:0] vprod_reg;
    logic signed [63:0] aprod_reg [2];
    logic signed [31:0] ax_reg [2];
    logic signed [63:0] yprod_reg [2];
    logic [31:0] lo_reg [2];
    logic [31:0] dl_reg [2];
    logic [K-1:0] r_reg [2];
    logic signed [17:0] n5_reg [2];
    logic [32:0] m_reg [2];
    logic signed [17:0] n6_reg [2];
    logic signed [31:0] e_reg [2];
    logic signed [63:0] tprod_reg [2];
    logic signed [31:0] t_reg [2];
    logic signed [31:0] sum_reg;
    logic signed [63:0] pprod_reg;
    logic signed [31:0] p_reg;
    logic signed [63:0] pprod2_reg;
    logic signed [31:0] out_reg;

    logic [NSTG:1] flag_next;
    logic signed [31:0] vel_next;
    logic signed [31:0] d_next;
    logic signed [31:0] lin_next;
    logic signed [31:0] ax_next [2];
    logic signed [31:0] e_next [2];
    logic signed [31:0] t_next [2];
    logic signed [31:0] sum_next;
    logic signed [31:0] p_next;
    logic signed [31:0] out_next;
    logic [1:0] ef_next;
    logic [1:0] tf_next;
    logic [2:0] af_next;
    logic [1:0] of_next;
    logic       vf_next;

    always_comb
    begin
        logic signed [32:0] dq;
        logic signed [32:0] lq;
        logic signed [65:0] vq;
        logic signed [65:0] vs;
        logic signed [65:0] w;
        logic signed [65:0] sq;
        logic [63:0] shv;
        logic signed [17:0] s;
        dq = 33'(joint_angle) - 33'(cfg_reg[REG_MID]);
        lq = 33'(joint_angle) - 33'(cfg_reg[REG_SLACK]);
        d_next = sat32(66'(dq));
        lin_next = sat32(66'(lq));
        af_next[0] = ovf32(66'(dq)) | ovf32(66'(lq));

        vq = rnd16(vprod_reg);
        vs = 66'(Q_ONE) - 66'(sat32(vq));
        vel_next = sat32(vs);
        vf_next = ovf32(vq) | ovf32(vs);

        af_next[2:1] = '0;
        for (int l = 0; l < 2; l++)
        begin
            w = rnd16(aprod_reg[l]);
            ax_next[l] = sat32(w);
            af_next[l + 1] = ovf32(w);
        end

        ef_next = '0;
        for (int l = 0; l < 2; l++)
        begin
            e_next[l] = '0;
            shv = '0;
            s = 18'sd14 - n6_reg[l];
            if (n6_reg[l] >= 18'sd15)
            begin
                e_next[l] = 32'sh7fffffff;
                ef_next[l] = 1'b1;
            end
            else if (n6_reg[l] == 18'sd14)
            begin
                e_next[l] = sat32(66'(signed'({1'b0, m_reg[l]})));
                ef_next[l] = ovf32(66'(signed'({1'b0, m_reg[l]})));
            end
            else if (s <= 18'sd40)
            begin
                shv = (64'(m_reg[l]) + (64'd1 << (s[5:0] - 6'd1))) >> s[5:0];
                e_next[l] = shv[31:0];
            end
        end

        tf_next = '0;
        for (int l = 0; l < 2; l++)
        begin
            w = rnd16(tprod_reg[l]);
            t_next[l] = sat32(w);
            tf_next[l] = ovf32(w);
        end
        sq = 66'(t_reg[0]) + 66'(t_reg[1]);
        sum_next = sat32(sq);

        w = rnd16(pprod_reg);
        p_next = sat32(w);
        of_next[0] = ovf32(w);

        w = rnd16(pprod2_reg);
        sq = 66'(sat32(w)) + 66'(cfg_reg[REG_EQ_TORQUE]);
        out_next = sat32(sq);
        of_next[1] = ovf32(w) | ovf32(sq);

        flag_next = '0;
        flag_next[1] = af_next[0];
        flag_next[2] = flag_reg[1] | vf_next;
        flag_next[3] = flag_reg[2] | af_next[1] | af_next[2];
        for (int i = 4; i <= 6; i++)
            flag_next[i] = flag_reg[i - 1];
        flag_next[7] = flag_reg[6] | ef_next[0] | ef_next[1];
        flag_next[8] = flag_reg[7];
        flag_next[9] = flag_reg[8] | tf_next[0] | tf_next[1];
        flag_next[10] = flag_reg[9] | ovf32(66'(t_reg[0]) + 66'(t_reg[1]));
        flag_next[11] = flag_reg[10];
        flag_next[12] = flag_reg[11] | of_next[0];
        flag_next[13] = flag_reg[12];
        flag_next[14] = flag_reg[13] | of_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[NSTG-1:1], start};
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;

        d_reg <= d_next;
        lin_reg[1] <= lin_next;
        vprod_reg <= 64'(joint_velocity) * 64'(cfg_reg[REG_VEL_GAIN]);
        vel_reg[2] <= vel_next;
        for (int i = 2; i <= LIN_TAP; i++)
            lin_reg[i] <= lin_reg[i - 1];
        for (int i = 3; i <= VEL_TAP; i++)
            vel_reg[i] <= vel_reg[i - 1];

        aprod_reg[0] <= 64'(cfg_reg[REG_RATE_ONE]) * 64'(d_reg);
        aprod_reg[1] <= 64'(cfg_reg[REG_RATE_TWO]) * 64'(d_reg);

        for (int l = 0; l < 2; l++)
        begin
            ax_reg[l] <= ax_next[l];
            yprod_reg[l] <= 64'(ax_reg[l]) * 64'(signed'({1'b0, LOG2E_Q30}));
            n5_reg[l] <= yprod_reg[l][63:46];
            lo_reg[l] <= pow_tbl[(EXP_TABLE_BITS+1)'(yprod_reg[l][45:30+K])];
            dl_reg[l] <= pow_tbl[(EXP_TABLE_BITS+1)'(yprod_reg[l][45:30+K]) + 1'b1]
                         - pow_tbl[(EXP_TABLE_BITS+1)'(yprod_reg[l][45:30+K])];
            r_reg[l] <= yprod_reg[l][30+K-1:30];
            m_reg[l] <= 33'(lo_reg[l]) + 33'((64'(dl_reg[l]) * 64'(r_reg[l])) >> K);
            n6_reg[l] <= n5_reg[l];
            e_reg[l] <= e_next[l];
            t_reg[l] <= t_next[l];
        end
        tprod_reg[0] <= 64'(cfg_reg[REG_GAIN_ONE]) * 64'(e_reg[0]);
        tprod_reg[1] <= 64'(cfg_reg[REG_GAIN_TWO]) * 64'(e_reg[1]);

        sum_reg <= sum_next;
        pprod_reg <= 64'(sum_reg) * 64'(vel_reg[VEL_TAP]);
        p_reg <= p_next;
        pprod2_reg <= 64'(p_reg) * 64'(lin_reg[LIN_TAP]);
        out_reg <= out_next;
    end

    assign busy = 1'b0;
    assign done = valid_reg[NSTG];
    assign torque = out_reg;
    assign saturated = flag_reg[NSTG];

endmodule
